// ===== sv/polyphase_rational_resampler_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the polyphase rational resampler
// Same-cycle and next-cycle implication checks, reset disables them.
// ----------------------------------------------------------------------------
`ifndef POLYPHASE_RATIONAL_RESAMPLER_TOP_MACROS_SVH
`define POLYPHASE_RATIONAL_RESAMPLER_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PRR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("prr check failed");

// antecedent implies consequent in the next cycle
`define PRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("prr check failed");

`endif

// ===== sv/prr_pkg.sv =====
// ----------------------------------------------------------------------------
// prr_pkg
// Shared constants and types of the polyphase rational resampler.
// ----------------------------------------------------------------------------
`default_nettype none

package prr_pkg;

	localparam int DEF_MAX_INTERP = 16;
	localparam int DEF_PHASE_LEN  = 16;
	localparam int DEF_MAX_DECIM  = 256;

	localparam int SMP_W    = 16;
	localparam int COEF_W   = 18;
	localparam int CADDR_W  = 8;
	localparam int INTERP_W = 5;
	localparam int DECIM_W  = 9;
	localparam int TAPS_W   = 5;
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;

	typedef enum logic [1:0] {
		REG_INTERP = 2'd0,
		REG_DECIM  = 2'd1,
		REG_TAPS   = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	// one tap issue into the MAC
	typedef struct packed {
		logic vld;
		logic clr;
	} mac_ctl_t;

endpackage

`default_nettype wire

// ===== sv/polyphase_rational_resampler_top.sv =====
// Sequencing: a coefficient beat is written and leaves the sequencer idle; a sample beat
//   runs, for each of the n outputs it produces, P tap issues, a MAC drain and an emit,
//   P = taps_per_phase. Throughput: one shared complex MAC, one tap per cycle; the input
//   is held off until the last output of a sample has been emitted.
// The last result may wait in the output register while the next beat is taken;
//   an emit stalls while that result is still held. Reset (arst_n low): history,
//   phase and result cleared, L=1 M=1 P=16; tap store is not cleared, no clearing pass.
// ----------------------------------------------------------------------------
// polyphase_rational_resampler_top
// Polyphase interpolate-by-L decimate-by-M FIR on complex 16-bit samples,
// Q1.16 taps in a RAM, one MAC stepped by a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module polyphase_rational_resampler_top #(
	parameter int MAX_INTERP = prr_pkg::DEF_MAX_INTERP,
	parameter int PHASE_LEN  = prr_pkg::DEF_PHASE_LEN,
	parameter int MAX_DECIM  = prr_pkg::DEF_MAX_DECIM
) (
	input  wire  logic                               clk,
	input  wire  logic                               arst_n,
	// item channel
	input  wire  logic                               item_valid,
	output logic                                     item_ready,
	input  wire  logic                               mode,
	input  wire  logic signed [prr_pkg::SMP_W-1:0]   sample_i,
	input  wire  logic signed [prr_pkg::SMP_W-1:0]   sample_q,
	input  wire  logic [prr_pkg::CADDR_W-1:0]        coef_addr,
	input  wire  logic signed [prr_pkg::COEF_W-1:0]  coef_value,
	// result channel
	output logic                                     res_valid,
	input  wire  logic                               res_ready,
	output logic signed [prr_pkg::SMP_W-1:0]         out_i,
	output logic signed [prr_pkg::SMP_W-1:0]         out_q,
	output logic                                     last,
	// configuration
	input  wire  logic                               psel,
	input  wire  logic                               penable,
	input  wire  logic                               pwrite,
	input  wire  logic [prr_pkg::APB_AW-1:0]         paddr,
	input  wire  logic [prr_pkg::APB_DW-1:0]         pwdata,
	output logic [prr_pkg::APB_DW-1:0]               prdata,
	output logic                                     pready
);

	localparam int STORE  = MAX_INTERP * PHASE_LEN;
	localparam int AW     = (STORE > 1) ? $clog2(STORE) : 1;
	localparam int KW     = (PHASE_LEN > 1) ? $clog2(PHASE_LEN) : 1;
	localparam int PW     = $clog2(PHASE_LEN + 1);
	localparam int LW     = $clog2(MAX_INTERP + 1);
	localparam int MW     = $clog2(MAX_DECIM + 1);
	localparam int TW     = $clog2(MAX_INTERP + MAX_DECIM + 1);
	localparam int HIST_D = (PHASE_LEN > 1) ? PHASE_LEN - 1 : 1;
	localparam int HW     = (HIST_D > 1) ? $clog2(HIST_D) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_WAIT,
		ST_EMIT
	} state_t;

	// ---------------- configuration registers ----------------
	logic [prr_pkg::INTERP_W-1:0] interp_q;
	logic [prr_pkg::DECIM_W-1:0]  decim_q;
	logic [prr_pkg::TAPS_W-1:0]   taps_q;
	prr_pkg::reg_idx_t            reg_idx;
	logic                         cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = prr_pkg::reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interp_q <= prr_pkg::INTERP_W'(1);
			decim_q  <= prr_pkg::DECIM_W'(1);
			taps_q   <= prr_pkg::TAPS_W'(16);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				prr_pkg::REG_INTERP: interp_q <= pwdata[prr_pkg::INTERP_W-1:0];
				prr_pkg::REG_DECIM:  decim_q  <= pwdata[prr_pkg::DECIM_W-1:0];
				prr_pkg::REG_TAPS:   taps_q   <= pwdata[prr_pkg::TAPS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			prr_pkg::REG_INTERP: prdata = prr_pkg::APB_DW'(interp_q);
			prr_pkg::REG_DECIM:  prdata = prr_pkg::APB_DW'(decim_q);
			prr_pkg::REG_TAPS:   prdata = prr_pkg::APB_DW'(taps_q);
			default:             prdata = '0;
		endcase
	end

	// clamped working values
	logic [LW-1:0] l_c;
	logic [MW-1:0] m_c;
	logic [PW-1:0] p_c;

	always_comb begin
		if (interp_q == '0) l_c = LW'(1);
		else if (32'(interp_q) > MAX_INTERP) l_c = LW'(MAX_INTERP);
		else l_c = LW'(interp_q);
		if (decim_q == '0) m_c = MW'(1);
		else if (32'(decim_q) > MAX_DECIM) m_c = MW'(MAX_DECIM);
		else m_c = MW'(decim_q);
		if (taps_q == '0) p_c = PW'(1);
		else if (32'(taps_q) > PHASE_LEN) p_c = PW'(PHASE_LEN);
		else p_c = PW'(taps_q);
	end

	// ---------------- sequencer ----------------
	state_t                            state_q;
	logic [KW-1:0]                     k_q;
	logic [TW-1:0]                     t_q, phase_q, t_next;
	logic signed [prr_pkg::SMP_W-1:0]  si_q, sq_q;
	logic                              res_valid_q, res_last_q;
	logic signed [prr_pkg::SMP_W-1:0]  res_i_q, res_q_q;

	logic                              acc_item, emit_go, emit_last, k_end;
	logic                              hist_shift;
	logic signed [prr_pkg::SMP_W-1:0]  hist_new_i, hist_new_q, hrd_i, hrd_q;
	logic signed [prr_pkg::SMP_W-1:0]  x_i, x_q, mac_i, mac_q;
	logic [HW-1:0]                     h_idx;
	logic [AW-1:0]                     raddr;
	logic                              coef_we, mac_busy;
	logic signed [prr_pkg::COEF_W-1:0] coef_rd;
	prr_pkg::mac_ctl_t                 mac_ctl;

	assign item_ready = (state_q == ST_IDLE);
	assign acc_item   = item_valid & item_ready;
	assign coef_we    = acc_item & mode & (32'(coef_addr) < STORE);
	assign t_next     = t_q + TW'(m_c);
	assign emit_last  = (32'(t_next) >= 32'(l_c));
	assign emit_go    = (state_q == ST_EMIT) & (~res_valid_q | res_ready);
	assign k_end      = (32'(k_q) == 32'(p_c) - 1);

	// stale phase shifts at accept; otherwise after the last output
	assign hist_shift = (acc_item & ~mode & (32'(phase_q) >= 32'(l_c))) |
	                    (emit_go & emit_last);
	assign hist_new_i = (state_q == ST_IDLE) ? sample_i : si_q;
	assign hist_new_q = (state_q == ST_IDLE) ? sample_q : sq_q;

	// window slot k: history tail, then the new sample at slot P-1
	assign h_idx   = HW'(32'(k_q) + PHASE_LEN - 32'(p_c));
	assign x_i     = k_end ? si_q : hrd_i;
	assign x_q     = k_end ? sq_q : hrd_q;
	assign raddr   = AW'(32'(t_q) * PHASE_LEN + 32'(k_q));
	assign mac_ctl = '{vld: (state_q == ST_MAC), clr: (k_q == '0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			t_q         <= '0;
			phase_q     <= '0;
			si_q        <= '0;
			sq_q        <= '0;
			res_valid_q <= 1'b0;
			res_last_q  <= 1'b0;
			res_i_q     <= '0;
			res_q_q     <= '0;
		end else begin
			// a new result replaces the one taken at this edge
			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc_item && !mode) begin
						si_q <= sample_i;
						sq_q <= sample_q;
						if (32'(phase_q) < 32'(l_c)) begin
							t_q     <= phase_q;
							k_q     <= '0;
							state_q <= ST_MAC;
						end else begin
							phase_q <= phase_q - TW'(l_c);
						end
					end
				end
				ST_MAC: begin
					if (k_end) begin
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_WAIT: begin
					if (!mac_busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						res_i_q     <= mac_i;
						res_q_q     <= mac_q;
						res_last_q  <= emit_last;
						k_q         <= '0;
						if (emit_last) begin
							phase_q <= t_next - TW'(l_c);
							state_q <= ST_IDLE;
						end else begin
							t_q     <= t_next;
							state_q <= ST_MAC;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign out_i     = res_i_q;
	assign out_q     = res_q_q;
	assign last      = res_last_q;

	// ---------------- datapath ----------------
	prr_coef_mem #(
		.DEPTH (STORE),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (coef_we),
		.waddr (AW'(coef_addr)),
		.wdata (coef_value),
		.raddr (raddr),
		.rdata (coef_rd)
	);

	prr_hist #(
		.PHASE_LEN (PHASE_LEN),
		.HIST_D    (HIST_D),
		.HW        (HW)
	) u_hist (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (hist_shift),
		.new_i  (hist_new_i),
		.new_q  (hist_new_q),
		.rd_idx (h_idx),
		.rd_i   (hrd_i),
		.rd_q   (hrd_q)
	);

	prr_mac #(
		.PHASE_LEN (PHASE_LEN)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.xi     (x_i),
		.xq     (x_q),
		.coef   (coef_rd),
		.busy   (mac_busy),
		.res_i  (mac_i),
		.res_q  (mac_q)
	);

endmodule

`default_nettype wire

// ===== sv/prr_coef_mem.sv =====
// ----------------------------------------------------------------------------
// prr_coef_mem
// Tap store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module prr_coef_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire  logic                              clk,
	input  wire  logic                              we,
	input  wire  logic [AW-1:0]                     waddr,
	input  wire  logic signed [prr_pkg::COEF_W-1:0] wdata,
	input  wire  logic [AW-1:0]                     raddr,
	output logic signed [prr_pkg::COEF_W-1:0]       rdata
);

	logic signed [prr_pkg::COEF_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== sv/prr_hist.sv =====
// ----------------------------------------------------------------------------
// prr_hist
// Sample history shift line, newest entry at the top, one read tap.
// ----------------------------------------------------------------------------
`default_nettype none

module prr_hist #(
	parameter int PHASE_LEN = 16,
	parameter int HIST_D    = (PHASE_LEN > 1) ? PHASE_LEN - 1 : 1,
	parameter int HW        = (HIST_D > 1) ? $clog2(HIST_D) : 1
) (
	input  wire  logic                             clk,
	input  wire  logic                             arst_n,
	input  wire  logic                             shift,
	input  wire  logic signed [prr_pkg::SMP_W-1:0] new_i,
	input  wire  logic signed [prr_pkg::SMP_W-1:0] new_q,
	input  wire  logic [HW-1:0]                    rd_idx,
	output logic signed [prr_pkg::SMP_W-1:0]       rd_i,
	output logic signed [prr_pkg::SMP_W-1:0]       rd_q
);

	generate
		if (PHASE_LEN > 1) begin : g_hist
			logic signed [prr_pkg::SMP_W-1:0] hi_q [HIST_D];
			logic signed [prr_pkg::SMP_W-1:0] hq_q [HIST_D];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					for (int j = 0; j < HIST_D; j++) begin
						hi_q[j] <= '0;
						hq_q[j] <= '0;
					end
				end else if (shift) begin
					for (int j = 0; j < HIST_D - 1; j++) begin
						hi_q[j] <= hi_q[j+1];
						hq_q[j] <= hq_q[j+1];
					end
					hi_q[HIST_D-1] <= new_i;
					hq_q[HIST_D-1] <= new_q;
				end
			end

			assign rd_i = hi_q[rd_idx];
			assign rd_q = hq_q[rd_idx];
		end else begin : g_nohist
			// single-tap branches never read history
			logic unused;
			assign unused = shift ^ new_i[0] ^ new_q[0] ^ rd_idx[0] ^ clk ^ arst_n;
			assign rd_i = '0;
			assign rd_q = '0;
		end
	endgenerate

endmodule

`default_nettype wire

// ===== sv/prr_mac.sv =====
// ----------------------------------------------------------------------------
// prr_mac
// Shared complex MAC: sample times tap, exact accumulate, round and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module prr_mac #(
	parameter int PHASE_LEN = 16
) (
	input  wire  logic                              clk,
	input  wire  logic                              arst_n,
	input  wire  prr_pkg::mac_ctl_t                 ctl,
	input  wire  logic signed [prr_pkg::SMP_W-1:0]  xi,
	input  wire  logic signed [prr_pkg::SMP_W-1:0]  xq,
	input  wire  logic signed [prr_pkg::COEF_W-1:0] coef,
	output logic                                    busy,
	output logic signed [prr_pkg::SMP_W-1:0]        res_i,
	output logic signed [prr_pkg::SMP_W-1:0]        res_q
);

	localparam int PROD_W = prr_pkg::SMP_W + prr_pkg::COEF_W;
	localparam int ACC_W  = PROD_W + $clog2(PHASE_LEN + 1);
	localparam int R_W    = ACC_W + 1;
	localparam logic signed [R_W-1:0] RND    = R_W'(32768);
	localparam logic signed [R_W-1:0] SAT_HI = R_W'(32767);
	localparam logic signed [R_W-1:0] SAT_LO = -R_W'(32768);

	logic                              vld_s1, vld_s2;
	logic signed [prr_pkg::SMP_W-1:0]  xi_s1, xq_s1;
	logic signed [PROD_W-1:0]          pi_s2, pq_s2;
	logic signed [ACC_W-1:0]           acc_i_q, acc_q_q;
	logic signed [R_W-1:0]             ri, rq, si, sq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= ctl.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		xi_s1 <= xi;
		xq_s1 <= xq;
		pi_s2 <= PROD_W'(xi_s1) * PROD_W'(coef);
		pq_s2 <= PROD_W'(xq_s1) * PROD_W'(coef);
		if (ctl.vld && ctl.clr) begin
			acc_i_q <= '0;
			acc_q_q <= '0;
		end else if (vld_s2) begin
			acc_i_q <= acc_i_q + ACC_W'(pi_s2);
			acc_q_q <= acc_q_q + ACC_W'(pq_s2);
		end
	end

	assign busy = vld_s1 | vld_s2;

	// add half an LSB, floor by 2^16, clamp to 16 bits
	always_comb begin
		ri = R_W'(acc_i_q) + RND;
		rq = R_W'(acc_q_q) + RND;
		si = ri >>> 16;
		sq = rq >>> 16;
		if (si > SAT_HI) res_i = prr_pkg::SMP_W'(SAT_HI);
		else if (si < SAT_LO) res_i = prr_pkg::SMP_W'(SAT_LO);
		else res_i = prr_pkg::SMP_W'(si);
		if (sq > SAT_HI) res_q = prr_pkg::SMP_W'(SAT_HI);
		else if (sq < SAT_LO) res_q = prr_pkg::SMP_W'(SAT_LO);
		else res_q = prr_pkg::SMP_W'(sq);
	end

endmodule

`default_nettype wire

// ===== sv/prr_checker.sv =====
// ----------------------------------------------------------------------------
// prr_checker
// Port-level checks of the resampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polyphase_rational_resampler_top_macros.svh"

module prr_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             item_valid,
	input wire logic                             item_ready,
	input wire logic                             mode,
	input wire logic                             res_valid,
	input wire logic                             res_ready,
	input wire logic signed [prr_pkg::SMP_W-1:0] out_i,
	input wire logic signed [prr_pkg::SMP_W-1:0] out_q,
	input wire logic                             last,
	input wire logic                             pready
);

	// a stalled result beat holds
	`PRR_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(out_i) && $stable(out_q) && $stable(last))

	// a coefficient beat never busies the sequencer
	`PRR_ASSERT_NEXT(a_coef_ready, clk, arst_n, item_valid && item_ready && mode, item_ready)

	// results only come out of a busy sequencer
	`PRR_ASSERT_SAME(a_res_src, clk, arst_n, $rose(res_valid), !$past(item_ready))

	// no wait states on the config port
	`PRR_ASSERT_SAME(a_pready, clk, arst_n, 1'b1, pready)

endmodule

bind polyphase_rational_resampler_top prr_checker u_prr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item_valid),
	.item_ready (item_ready),
	.mode       (mode),
	.res_valid  (res_valid),
	.res_ready  (res_ready),
	.out_i      (out_i),
	.out_q      (out_q),
	.last       (last),
	.pready     (pready)
);

`default_nettype wire
